// ===== design/prq_pkg.sv =====
// Package for the priority ready queue: sizes, operation and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package prq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PID_W       = 4;
    localparam int PRIO_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    // operation codes carried on s_tuser
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DEQ_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ENQ_FULL  = 2'd2;

    typedef struct packed {
        logic                load;     // capture a result this cycle
        logic                do_enq;   // insert the new id
        logic                do_deq;   // remove the head
        logic [STATUS_W-1:0] status;   // status code for the result
    } prq_cmd_t;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [COUNT_W-1:0] count;
    } prq_stat_t;

endpackage

// ===== design/prq_ctrl.sv =====
// Controller for the priority ready queue: output register occupancy and
// per-transfer decode of the operation. Depends on prq_pkg.
`timescale 1ns / 1ps

module prq_ctrl
    import prq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      op,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  prq_stat_t stat,
    output prq_cmd_t  cmd
);

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_HOLD  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_tready = (state_reg == ST_EMPTY) || m_tready;
    assign m_tvalid = (state_reg == ST_HOLD);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd        = '0;
        cmd.load   = accept;
        cmd.status = STAT_OK;
        if (accept) begin
            case (op)
                CMD_ENQ: begin
                    if (stat.full) begin
                        cmd.status = STAT_ENQ_FULL;
                    end else begin
                        cmd.do_enq = 1'b1;
                    end
                end
                CMD_DEQ: begin
                    if (stat.empty) begin
                        cmd.status = STAT_DEQ_EMPTY;
                    end else begin
                        cmd.do_deq = 1'b1;
                    end
                end
                default: cmd.status = STAT_OK;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY: if (accept) state_next = ST_HOLD;
            ST_HOLD:  if (m_tready && !accept) state_next = ST_EMPTY;
            default:  state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/prq_datapath.sv =====
// Datapath for the priority ready queue: sorted shift-register slots,
// entry count and the result register. Depends on prq_pkg.
`timescale 1ns / 1ps

module prq_datapath
    import prq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  prq_cmd_t            cmd,
    input  logic [PID_W-1:0]    new_pid,
    input  logic [PRIO_W-1:0]   new_priority,
    output prq_stat_t           stat,
    output logic [PID_W-1:0]    out_pid,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  fill_count
);

    logic [PID_W-1:0]    pid_reg   [QUEUE_DEPTH];
    logic [PRIO_W-1:0]   prio_reg  [QUEUE_DEPTH];
    logic [PID_W-1:0]    pid_next  [QUEUE_DEPTH];
    logic [PRIO_W-1:0]   prio_next [QUEUE_DEPTH];
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [QUEUE_DEPTH-1:0] stay;

    logic [PID_W-1:0]    out_pid_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  fill_reg;

    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == COUNT_W'(QUEUE_DEPTH));

    // Slots at or above the new priority keep their place; the list is sorted
    // so this is a prefix and the insert point is its first zero.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            stay[i] = (COUNT_W'(i) < count_reg) && (prio_reg[i] >= new_priority);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            pid_next[i]  = pid_reg[i];
            prio_next[i] = prio_reg[i];
            if (cmd.do_enq && !stay[i]) begin
                if (i == 0 || stay[(i == 0) ? 0 : i - 1]) begin
                    pid_next[i]  = new_pid;
                    prio_next[i] = new_priority;
                end else begin
                    pid_next[i]  = pid_reg[(i == 0) ? 0 : i - 1];
                    prio_next[i] = prio_reg[(i == 0) ? 0 : i - 1];
                end
            end else if (cmd.do_deq && i < QUEUE_DEPTH - 1) begin
                pid_next[i]  = pid_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                prio_next[i] = prio_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.do_enq) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (cmd.do_deq) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            pid_reg[i]  <= pid_next[i];
            prio_reg[i] <= prio_next[i];
        end
        if (cmd.load) begin
            out_pid_reg   <= cmd.do_deq ? pid_reg[0] : '0;
            out_valid_reg <= cmd.do_deq;
            status_reg    <= cmd.status;
            fill_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign out_pid    = out_pid_reg;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign fill_count = fill_reg;

endmodule

// ===== design/priority_ready_queue.sv =====
// Top level of the priority ready queue: controller plus datapath.
// Depends on prq_pkg, prq_ctrl and prq_datapath.
//
//   channel   direction  tdata (low bit up)               tuser
//   s_        in         new_pid[3:0], new_priority[11:4]  cmd
//   m_        out        out_pid[3:0], fill_count[8:4]     out_valid[0], status[2:1]
//
// On each transfer all slots compare against the new priority
// in parallel and shift in the same edge, and the result lands in one output
// register. A new transfer is taken while that register is empty or being
// drained, so the block sustains one item per cycle. When m_tready is low while
// a result is held, the result holds and s_tready drops. Reset empties the queue at once; slot
// contents are left as they are.
`timescale 1ns / 1ps

module priority_ready_queue
    import prq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // new_pid[3:0], new_priority[11:4], zero pad
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_pid[3:0], fill_count[8:4], zero pad
    output logic [2:0]  m_tuser    // out_valid[0], status[2:1]
);

    prq_cmd_t            cmd;
    prq_stat_t           stat;
    logic [PID_W-1:0]    out_pid;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  fill_count;

    prq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prq_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .new_pid      (s_tdata[3:0]),
        .new_priority (s_tdata[11:4]),
        .stat         (stat),
        .out_pid      (out_pid),
        .out_valid    (out_valid),
        .status       (status),
        .fill_count   (fill_count)
    );

    assign m_tdata = {7'd0, fill_count, out_pid};
    assign m_tuser = {status, out_valid};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= COUNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) |=> $stable(stat.count))
        else $error("entry count changed without a transfer");

    a_deq_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_DEQ && stat.empty)
        |=> (m_tuser[2:1] == STAT_DEQ_EMPTY && !m_tuser[0]))
        else $error("dequeue from empty queue not flagged");

    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == STAT_OK))
        else $error("removed id reported with error status");
`endif

endmodule

// ===== sim/priority_ready_queue_tb.sv =====
// Self-checking testbench for priority_ready_queue: an internal priority-order
// predictor checks every result transfer against the expected queue output.
// Depends on prq_pkg and the priority_ready_queue RTL.
`timescale 1ns / 1ps

module priority_ready_queue_tb;
    import prq_pkg::*;

    typedef struct {
        logic              cmd;
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
    } queue_op_t;

    typedef struct {
        logic [PID_W-1:0]    pid;
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  fill;
    } queue_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // new_pid[3:0], new_priority[11:4], zero pad
    logic        s_tuser  = 1'b0; // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // out_pid[3:0], fill_count[8:4], zero pad
    logic [2:0]  m_tuser;         // out_valid[0], status[2:1]

    queue_op_t     pending_ops[$];
    queue_result_t expected_results[$];

    // predictor state: slot 0 is the head
    logic [PID_W-1:0]  model_pid[QUEUE_DEPTH];
    logic [PRIO_W-1:0] model_prio[QUEUE_DEPTH];
    int                model_count = 0;

    int  mismatch_count = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_pct = 0;
    int  stall_left = 0;
    bit  hold_item;

    priority_ready_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Apply one operation to the predicted queue and return its result.
    function automatic queue_result_t apply_queue_op(queue_op_t op);
        queue_result_t r;
        int pos;
        r.pid    = '0;
        r.valid  = 1'b0;
        r.status = STAT_OK;
        if (op.cmd == CMD_DEQ) begin
            if (model_count == 0) begin
                r.status = STAT_DEQ_EMPTY;
            end else begin
                r.pid   = model_pid[0];
                r.valid = 1'b1;
                for (int k = 1; k < model_count; k++) begin
                    model_pid[k-1]  = model_pid[k];
                    model_prio[k-1] = model_prio[k];
                end
                model_count--;
            end
        end else begin
            if (model_count >= QUEUE_DEPTH) begin
                r.status = STAT_ENQ_FULL;
            end else begin
                // insert behind every entry of equal or higher priority
                pos = 0;
                while (pos < model_count && model_prio[pos] >= op.prio)
                    pos++;
                for (int k = model_count; k > pos; k--) begin
                    model_pid[k]  = model_pid[k-1];
                    model_prio[k] = model_prio[k-1];
                end
                model_pid[pos]  = op.pid;
                model_prio[pos] = op.prio;
                model_count++;
            end
        end
        r.fill = COUNT_W'(model_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic push_op(logic cmd, int pid, int prio);
        queue_op_t op;
        op.cmd  = cmd;
        op.pid  = PID_W'(pid);
        op.prio = PRIO_W'(prio);
        pending_ops.push_back(op);
    endtask

    // Driver: bursts of transfers separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_queue_op(pending_ops[0]));
                pending_ops.pop_front();
                if (burst_left > 0)
                    burst_left--;
            end
            hold_item = s_tvalid && !s_tready;
            if (!hold_item) begin
                if (pending_ops.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    if (gap_left > 0) begin
                        gap_left--;
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid <= 1'b1;
                        s_tdata  <= {4'b0, pending_ops[0].prio, pending_ops[0].pid};
                        s_tuser  <= pending_ops[0].cmd;
                    end
                end
            end
        end
    end

    // Monitor: check each result transfer, stall in phases of varying density.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, pid", int'(m_tdata[3:0]), 0);
                end else begin
                    if (m_tdata[3:0] !== expected_results[0].pid)
                        report_mismatch("out_pid", int'(m_tdata[3:0]),
                                        int'(expected_results[0].pid));
                    if (m_tuser[0] !== expected_results[0].valid)
                        report_mismatch("out_valid", int'(m_tuser[0]),
                                        int'(expected_results[0].valid));
                    if (m_tuser[2:1] !== expected_results[0].status)
                        report_mismatch("status", int'(m_tuser[2:1]),
                                        int'(expected_results[0].status));
                    if (m_tdata[8:4] !== expected_results[0].fill)
                        report_mismatch("fill_count", int'(m_tdata[8:4]),
                                        int'(expected_results[0].fill));
                    if (m_tdata[15:9] !== '0)
                        report_mismatch("tdata pad", int'(m_tdata[15:9]), 0);
                    expected_results.pop_front();
                end
            end
            if (stall_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                stall_left = $urandom_range(10, 80);
            end
            stall_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin : stimulus
        int enq_pct;
        int seg_left;
        int random_ops;
        int prio;

        // directed: empty dequeue, extremes, ties, fill to full, overflow
        push_op(CMD_DEQ, 0, 0);
        push_op(CMD_ENQ, 15, 255);
        push_op(CMD_ENQ, 0, 0);
        push_op(CMD_ENQ, 5, 128);
        push_op(CMD_ENQ, 6, 128);
        push_op(CMD_ENQ, 7, 128);
        push_op(CMD_ENQ, 15, 255);
        push_op(CMD_ENQ, 1, 0);
        push_op(CMD_ENQ, 3, 128);
        for (int i = 0; i < 8; i++)
            push_op(CMD_ENQ, i + 8, 85 * (i % 4));
        push_op(CMD_ENQ, 9, 200);
        for (int i = 0; i < 5; i++)
            push_op(CMD_DEQ, 15, 255);

        // random walk: segments biased toward filling or draining
        random_ops = 0;
        seg_left   = 0;
        enq_pct    = 50;
        while (random_ops < 1200) begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 2))
                    0: enq_pct = 15;
                    1: enq_pct = 50;
                    default: enq_pct = 85;
                endcase
                seg_left = $urandom_range(20, 60);
            end
            // coarse priorities half the time to force ties
            prio = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
                                               : 85 * $urandom_range(0, 3);
            push_op(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
                    $urandom_range(0, 15), prio);
            seg_left--;
            random_ops++;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/prq_pkg.sv
design/prq_ctrl.sv
design/prq_datapath.sv
design/priority_ready_queue.sv
sim/priority_ready_queue_tb.sv
